// ===== src/caspid_pkg.sv =====
// ----------------------------------------------------------------------------
// caspid_pkg
// Shared types and constants of the cascaded angle / speed controller.
// ----------------------------------------------------------------------------
package caspid_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SPEED_KP       = 3'd0,
        CFG_SPEED_KI       = 3'd1,
        CFG_SPEED_KD       = 3'd2,
        CFG_ANGLE_KP       = 3'd3,
        CFG_ANGLE_KD       = 3'd4,
        CFG_INTEGRAL_BAND  = 3'd5,
        CFG_INTEGRAL_LIMIT = 3'd6,
        CFG_DRIVE_LIMIT    = 3'd7
    } caspid_cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // request kinds carried in tuser
    localparam logic REQ_SPEED = 1'b0;
    localparam logic REQ_ANGLE = 1'b1;

    // errors of this magnitude or less force zero drive
    localparam logic [16:0] DEADBAND = 17'd2;

    // register file seen by the loop datapaths
    typedef struct packed {
        logic [15:0] speed_kp;
        logic [15:0] speed_ki;
        logic [15:0] speed_kd;
        logic [15:0] angle_kp;
        logic [15:0] angle_kd;
        logic [15:0] integral_band;
        logic [19:0] integral_limit;
        logic [14:0] drive_limit;
    } caspid_cfg_t;

endpackage

// ===== src/caspid_angle_step.sv =====
// ----------------------------------------------------------------------------
// caspid_angle_step
// Outer angle PD law: error, Q8.8 terms, clamp to the speed target range.
// ----------------------------------------------------------------------------
module caspid_angle_step #(
    parameter int SPEED_TARGET_MAX = 16000
) (
    input  caspid_pkg::caspid_cfg_t cfg,
    input  logic signed [31:0]      measured_angle,
    input  logic signed [31:0]      angle_cmd,
    input  logic signed [32:0]      prev_err,
    output logic signed [32:0]      err_next,
    output logic signed [15:0]      goal_next
);
    import caspid_pkg::*;

    localparam logic signed [43:0] GOAL_MAX = 44'(SPEED_TARGET_MAX);

    logic signed [16:0] kp_s;
    logic signed [16:0] kd_s;
    logic signed [33:0] diff;
    logic signed [49:0] p_prod;
    logic signed [50:0] d_prod;
    logic signed [41:0] p_term;
    logic signed [42:0] d_term;
    logic signed [43:0] total;

    // error and its change since the last angle step
    assign err_next = 33'(angle_cmd) - 33'(measured_angle);
    assign diff     = 34'(err_next) - 34'(prev_err);

    // gains are unsigned, widened with a zero sign bit
    assign kp_s   = signed'({1'b0, cfg.angle_kp});
    assign kd_s   = signed'({1'b0, cfg.angle_kd});
    assign p_prod = 50'(kp_s) * 50'(err_next);
    assign d_prod = 51'(kd_s) * 51'(diff);

    // drop eight fraction bits, rounding toward minus infinity
    assign p_term = signed'(p_prod[49:8]);
    assign d_term = signed'(d_prod[50:8]);
    assign total  = 44'(p_term) + 44'(d_term);

    // symmetric clamp of the speed target
    always_comb
    begin
        if (total > GOAL_MAX)
            goal_next = GOAL_MAX[15:0];
        else if (total < -GOAL_MAX)
            goal_next = 16'(-GOAL_MAX);
        else
            goal_next = total[15:0];
    end

endmodule

// ===== src/caspid_speed_step.sv =====
// ----------------------------------------------------------------------------
// caspid_speed_step
// Inner speed PID law with integral separation, integral clamp and drive
// saturation.
// ----------------------------------------------------------------------------
module caspid_speed_step (
    input  caspid_pkg::caspid_cfg_t cfg,
    input  logic signed [15:0]      measured_speed,
    input  logic signed [15:0]      speed_goal,
    input  logic signed [20:0]      err_sum,
    input  logic signed [16:0]      prev_err,
    output logic signed [20:0]      err_sum_next,
    output logic signed [16:0]      err_next,
    output logic signed [15:0]      drive_next
);
    import caspid_pkg::*;

    logic        [16:0] mag;
    logic               integrate;
    logic signed [21:0] acc;
    logic signed [21:0] int_lim;
    logic signed [16:0] kp_s;
    logic signed [16:0] ki_s;
    logic signed [16:0] kd_s;
    logic signed [17:0] diff;
    logic signed [33:0] p_prod;
    logic signed [37:0] i_prod;
    logic signed [34:0] d_prod;
    logic signed [25:0] p_term;
    logic signed [29:0] i_term;
    logic signed [26:0] d_term;
    logic signed [31:0] total;
    logic signed [31:0] drv_lim;

    // speed error and its magnitude
    assign err_next = 17'(speed_goal) - 17'(measured_speed);
    assign mag      = err_next[16] ? 17'(-err_next) : 17'(err_next);

    // integrate only inside the band, then clamp the accumulator
    assign integrate = (mag <= {1'b0, cfg.integral_band});
    assign acc       = integrate ? 22'(err_sum) + 22'(err_next) : 22'(err_sum);
    assign int_lim   = signed'({2'b00, cfg.integral_limit});

    always_comb
    begin
        if (acc > int_lim)
            err_sum_next = int_lim[20:0];
        else if (acc < -int_lim)
            err_sum_next = 21'(-int_lim);
        else
            err_sum_next = acc[20:0];
    end

    // Q8.8 terms, each floored after its product
    assign kp_s   = signed'({1'b0, cfg.speed_kp});
    assign ki_s   = signed'({1'b0, cfg.speed_ki});
    assign kd_s   = signed'({1'b0, cfg.speed_kd});
    assign diff   = 18'(err_next) - 18'(prev_err);
    assign p_prod = 34'(kp_s) * 34'(err_next);
    assign i_prod = 38'(ki_s) * 38'(err_sum_next);
    assign d_prod = 35'(kd_s) * 35'(diff);
    assign p_term = signed'(p_prod[33:8]);
    assign i_term = signed'(i_prod[37:8]);
    assign d_term = signed'(d_prod[34:8]);
    assign total  = 32'(p_term) + 32'(i_term) + 32'(d_term);

    // dead band, then symmetric drive saturation
    assign drv_lim = signed'({17'd0, cfg.drive_limit});

    always_comb
    begin
        if (mag <= DEADBAND)
            drive_next = '0;
        else if (total > drv_lim)
            drive_next = drv_lim[15:0];
        else if (total < -drv_lim)
            drive_next = 16'(-drv_lim);
        else
            drive_next = total[15:0];
    end

endmodule

// ===== src/cascaded_angle_speed_pid.sv =====
// ----------------------------------------------------------------------------
// cascaded_angle_speed_pid
// Cascaded motor controller: angle PD loop feeding a speed PID loop.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the result side is not stalled. An
// accepted request is held in an input register, then its whole loop update
// (error, speed integral clamp, 2-3 Q8.8 products, sum, saturation) is computed
// combinationally from that register and written into the loop state, which
// also forms the result; a result passes through the input register and the
// loop state register, and a stalled result side holds both. Angle requests
// (tuser = 1) update the speed target, speed requests (tuser = 0) update the
// drive; every request returns one result carrying both current values.
// Configuration writes are taken at any time (cfg_ready is always high) and
// must only be made while no request is in flight.
// ----------------------------------------------------------------------------
module cascaded_angle_speed_pid #(
    parameter int SPEED_TARGET_MAX = 16000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [caspid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [caspid_pkg::CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [15:0] measured_speed, [47:16] measured_angle, [79:48] angle_cmd
    input  logic [79:0]                       s_axis_tdata,
    // [0] req_type
    input  logic                              s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [15:0] drive_out, [31:16] speed_setpoint
    output logic [31:0]                       m_axis_tdata
);
    import caspid_pkg::*;

    caspid_cfg_t        cfg_reg;

    logic               in_valid_reg;
    logic               in_req_reg;
    logic signed [15:0] in_speed_reg;
    logic signed [31:0] in_angle_reg;
    logic signed [31:0] in_target_reg;

    logic               out_valid_reg;
    logic signed [20:0] speed_err_sum_reg;
    logic signed [16:0] speed_prev_err_reg;
    logic signed [32:0] angle_prev_err_reg;
    logic signed [15:0] speed_goal_reg;
    logic signed [15:0] drive_hold_reg;

    logic signed [20:0] speed_err_sum_next;
    logic signed [16:0] speed_prev_err_next;
    logic signed [32:0] angle_prev_err_next;
    logic signed [15:0] speed_goal_next;
    logic signed [15:0] drive_hold_next;

    logic               advance;
    logic               fire;
    logic               in_fire;

    // handshakes
    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SPEED_KP:       cfg_reg.speed_kp       <= cfg_data[15:0];
                CFG_SPEED_KI:       cfg_reg.speed_ki       <= cfg_data[15:0];
                CFG_SPEED_KD:       cfg_reg.speed_kd       <= cfg_data[15:0];
                CFG_ANGLE_KP:       cfg_reg.angle_kp       <= cfg_data[15:0];
                CFG_ANGLE_KD:       cfg_reg.angle_kd       <= cfg_data[15:0];
                CFG_INTEGRAL_BAND:  cfg_reg.integral_band  <= cfg_data[15:0];
                CFG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data[19:0];
                CFG_DRIVE_LIMIT:    cfg_reg.drive_limit    <= cfg_data[14:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // input stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_req_reg    <= s_axis_tuser;
            in_speed_reg  <= signed'(s_axis_tdata[15:0]);
            in_angle_reg  <= signed'(s_axis_tdata[47:16]);
            in_target_reg <= signed'(s_axis_tdata[79:48]);
        end
    end

    // loop datapaths
    caspid_angle_step #(
        .SPEED_TARGET_MAX (SPEED_TARGET_MAX)
    ) u_angle (
        .cfg            (cfg_reg),
        .measured_angle (in_angle_reg),
        .angle_cmd      (in_target_reg),
        .prev_err       (angle_prev_err_reg),
        .err_next       (angle_prev_err_next),
        .goal_next      (speed_goal_next)
    );

    caspid_speed_step u_speed (
        .cfg            (cfg_reg),
        .measured_speed (in_speed_reg),
        .speed_goal     (speed_goal_reg),
        .err_sum        (speed_err_sum_reg),
        .prev_err       (speed_prev_err_reg),
        .err_sum_next   (speed_err_sum_next),
        .err_next       (speed_prev_err_next),
        .drive_next     (drive_hold_next)
    );

    // loop state doubles as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg      <= 1'b0;
            speed_err_sum_reg  <= '0;
            speed_prev_err_reg <= '0;
            angle_prev_err_reg <= '0;
            speed_goal_reg     <= '0;
            drive_hold_reg     <= '0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (fire)
            begin
                if (in_req_reg == REQ_ANGLE)
                begin
                    angle_prev_err_reg <= angle_prev_err_next;
                    speed_goal_reg     <= speed_goal_next;
                end
                else
                begin
                    speed_err_sum_reg  <= speed_err_sum_next;
                    speed_prev_err_reg <= speed_prev_err_next;
                    drive_hold_reg     <= drive_hold_next;
                end
            end
        end
    end

    // result transaction
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {speed_goal_reg, drive_hold_reg};

endmodule

// ===== src/caspid_checker.sv =====
// ----------------------------------------------------------------------------
// caspid_checker
// Port-level checks of the cascaded controller, bound to the top level.
// ----------------------------------------------------------------------------
module caspid_checker #(
    parameter int SPEED_TARGET_MAX = 16000
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    localparam logic signed [16:0] GOAL_MAX = 17'(SPEED_TARGET_MAX);

    // no result valid just after reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("result valid during reset");

    // a stalled result keeps its value
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // an empty result side always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty result side");

    // speed target stays inside its clamp
    a_goal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed({m_axis_tdata[31], m_axis_tdata[31:16]}) <= GOAL_MAX)
                       && ($signed({m_axis_tdata[31], m_axis_tdata[31:16]}) >= -GOAL_MAX))
        else $error("speed target outside clamp");

    // symmetric saturation never yields the most negative drive
    a_drive_sym: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000)
        else $error("drive outside symmetric range");

endmodule

bind cascaded_angle_speed_pid caspid_checker #(
    .SPEED_TARGET_MAX (SPEED_TARGET_MAX)
) u_caspid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/cascaded_angle_speed_pid_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_angle_speed_pid_tb
// Self-checking bench for the cascaded angle / speed controller.
// ----------------------------------------------------------------------------
// Drives angle and speed requests into the request stream and predicts every
// result with a cycle-free model of both loops kept in the bench. Directed
// tests cover field extremes, the first derivative step, the deadband and
// integration band edges, a lowered integral limit and zero or full-scale
// limits. A long random run follows under several register settings, with
// random gaps on both streams, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module cascaded_angle_speed_pid_tb;

    import caspid_pkg::*;

    localparam int SPEED_GOAL_MAX = 16000;
    localparam int IDLE_LIMIT     = 3000;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int PRINT_LIMIT    = 50;

    // result fields, drive in the low half of tdata
    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] drive;
    } result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [15:0] measured_speed, [47:16] measured_angle, [79:48] angle_cmd
    logic [79:0]           s_axis_tdata = '0;
    // [0] req_type
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] drive_out, [31:16] speed_setpoint
    logic [31:0]           m_axis_tdata;

    // controller state mirrored by the predictor
    caspid_cfg_t regs = '0;
    longint      speed_err_acc = 0;
    longint      speed_err_prev = 0;
    longint      angle_err_prev = 0;
    longint      speed_goal_now = 0;
    longint      drive_now = 0;

    result_t     pending_results[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    cascaded_angle_speed_pid #(
        .SPEED_TARGET_MAX (SPEED_GOAL_MAX)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint clamp_sym(longint x, longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // one loop update, returns the result the block should show
    function automatic result_t step_controller(logic req, logic [15:0] speed_meas,
                                                logic [31:0] angle_meas,
                                                logic [31:0] angle_cmd);
        longint  err;
        longint  mag;
        longint  sum;
        longint  p_term;
        longint  i_term;
        longint  d_term;
        result_t r;
        if (req == REQ_ANGLE)
        begin
            // outer loop: pd on angle error, clamped into the speed goal
            err = longint'($signed(angle_cmd)) - longint'($signed(angle_meas));
            p_term = (longint'(regs.angle_kp) * err) >>> 8;
            d_term = (longint'(regs.angle_kd) * (err - angle_err_prev)) >>> 8;
            angle_err_prev = err;
            speed_goal_now = clamp_sym(p_term + d_term, SPEED_GOAL_MAX);
        end
        else
        begin
            // inner loop: pid with integration only inside the band
            err = speed_goal_now - longint'($signed(speed_meas));
            mag = (err < 0) ? -err : err;
            sum = speed_err_acc;
            if (mag <= longint'(regs.integral_band))
                sum += err;
            sum = clamp_sym(sum, longint'(regs.integral_limit));
            speed_err_acc = sum;
            p_term = (longint'(regs.speed_kp) * err) >>> 8;
            i_term = (longint'(regs.speed_ki) * sum) >>> 8;
            d_term = (longint'(regs.speed_kd) * (err - speed_err_prev)) >>> 8;
            speed_err_prev = err;
            if (mag <= longint'(DEADBAND))
                drive_now = 0;
            else
                drive_now = clamp_sym(p_term + i_term + d_term,
                                      longint'(regs.drive_limit));
        end
        r.drive    = drive_now[15:0];
        r.setpoint = speed_goal_now[15:0];
        return r;
    endfunction

    // mostly short idle runs, now and then a long one
    function automatic int pick_gap_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // offer one request and predict its result once the transaction is taken
    task automatic send_request(logic req, logic [15:0] speed_meas,
                                logic [31:0] angle_meas, logic [31:0] angle_cmd);
        int gap;
        gap = ($urandom_range(0, 99) < tx_gap_pct) ? pick_gap_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {angle_cmd, angle_meas, speed_meas};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(step_controller(req, speed_meas, angle_meas,
                                                  angle_cmd));
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // write the whole register file while the block is idle
    task automatic write_config(caspid_cfg_t c);
        caspid_cfg_idx_t idx;
        drain_results();
        idx = idx.first();
        do
        begin
            cfg_index <= idx;
            case (idx)
                CFG_SPEED_KP:       cfg_data <= CFG_DATA_W'(c.speed_kp);
                CFG_SPEED_KI:       cfg_data <= CFG_DATA_W'(c.speed_ki);
                CFG_SPEED_KD:       cfg_data <= CFG_DATA_W'(c.speed_kd);
                CFG_ANGLE_KP:       cfg_data <= CFG_DATA_W'(c.angle_kp);
                CFG_ANGLE_KD:       cfg_data <= CFG_DATA_W'(c.angle_kd);
                CFG_INTEGRAL_BAND:  cfg_data <= CFG_DATA_W'(c.integral_band);
                CFG_INTEGRAL_LIMIT: cfg_data <= CFG_DATA_W'(c.integral_limit);
                default:            cfg_data <= CFG_DATA_W'(c.drive_limit);
            endcase
            cfg_valid <= 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_valid <= 1'b0;
        regs = c;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'($urandom);
            default: return 16'($urandom_range(1, 16'h0400));
        endcase
    endfunction

    function automatic caspid_cfg_t random_config();
        caspid_cfg_t c;
        c.speed_kp       = pick_gain();
        c.speed_ki       = pick_gain();
        c.speed_kd       = pick_gain();
        c.angle_kp       = pick_gain();
        c.angle_kd       = pick_gain();
        c.integral_band  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 2000));
        c.integral_limit = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                       : 20'($urandom_range(0, 50000));
        c.drive_limit    = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                       : 15'($urandom_range(0, 12000));
        return c;
    endfunction

    // random request, mostly with errors near the interesting thresholds
    task automatic random_request();
        logic [15:0] speed_meas;
        logic [31:0] angle_meas;
        logic [31:0] angle_cmd;
        int          off;
        angle_meas = $urandom;
        angle_cmd  = $urandom;
        speed_meas = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                angle_cmd = angle_meas + $urandom_range(0, 4000) - 2000;
                send_request(REQ_ANGLE, speed_meas, angle_meas, angle_cmd);
            end
            2:
                send_request(REQ_ANGLE, speed_meas, angle_meas, angle_cmd);
            3, 4, 5:
            begin
                // error inside or just outside the integration band
                off = $urandom_range(0, int'(regs.integral_band) + 3);
                if ($urandom_range(0, 1))
                    off = -off;
                speed_meas = 16'(speed_goal_now - off);
                send_request(REQ_SPEED, speed_meas, angle_meas, angle_cmd);
            end
            6, 7:
            begin
                // around the deadband
                off = $urandom_range(0, 8) - 4;
                speed_meas = 16'(speed_goal_now - off);
                send_request(REQ_SPEED, speed_meas, angle_meas, angle_cmd);
            end
            default:
                send_request(REQ_SPEED, speed_meas, angle_meas, angle_cmd);
        endcase
    endtask

    // output side: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < rx_stall_pct)
        begin
            stall_left = pick_gap_len() - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // compare each result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with none expected, tdata %h",
                                          m_axis_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (got.drive !== want.drive)
                    report_mismatch($sformatf("drive_out %0d, expected %0d",
                                              got.drive, want.drive));
                if (got.setpoint !== want.setpoint)
                    report_mismatch($sformatf("speed_setpoint %0d, expected %0d",
                                              got.setpoint, want.setpoint));
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // derivative uses a zero previous error straight after reset
    task automatic test_first_step_derivative();
        caspid_cfg_t c;
        c.speed_kp       = 16'h0100;
        c.speed_ki       = 16'h0010;
        c.speed_kd       = 16'h0100;
        c.angle_kp       = 16'h0100;
        c.angle_kd       = 16'h0100;
        c.integral_band  = 16'd500;
        c.integral_limit = 20'd4000;
        c.drive_limit    = 15'd30000;
        write_config(c);
        send_request(REQ_ANGLE, 16'h0000, 32'd0, 32'd1000);
        send_request(REQ_SPEED, 16'h0000, 32'd0, 32'd0);
    endtask

    // extreme field values, goal clamped both ways
    task automatic test_extreme_fields();
        send_request(REQ_ANGLE, 16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_ANGLE, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(REQ_SPEED, 16'h8000, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_SPEED, 16'h7FFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_ANGLE, 16'h5555, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_SPEED, 16'hFFFF, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // deadband edges and integration band edges
    task automatic test_deadband_and_band();
        longint band;
        band = longint'(regs.integral_band);
        send_request(REQ_ANGLE, 16'h0000, 32'd0, 32'd300);
        send_request(REQ_SPEED, 16'(speed_goal_now - 2), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now + 2), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now - 3), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now + 3), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now - band), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now + band + 1), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now), 32'd0, 32'd0);
    endtask

    // accumulator above a newly lowered limit gets clamped on the next step
    task automatic test_limit_lowered();
        caspid_cfg_t c;
        c = regs;
        c.speed_ki       = 16'h0080;
        c.integral_band  = 16'hFFFF;
        c.integral_limit = 20'hFFFFF;
        write_config(c);
        repeat (3)
            send_request(REQ_SPEED, 16'h8000, 32'd0, 32'd0);
        c.integral_limit = 20'd100;
        write_config(c);
        send_request(REQ_SPEED, 16'(speed_goal_now - 10), 32'd0, 32'd0);
    endtask

    // zero limits pin drive and accumulator, then full-scale registers
    task automatic test_zero_and_full_limits();
        caspid_cfg_t c;
        c = '1;
        c.integral_limit = '0;
        c.drive_limit    = '0;
        write_config(c);
        send_request(REQ_SPEED, 16'(speed_goal_now - 1000), 32'd0, 32'd0);
        send_request(REQ_SPEED, 16'(speed_goal_now + 1000), 32'd0, 32'd0);
        write_config('1);
        send_request(REQ_ANGLE, 16'h0000, -32'sd5000, 32'd5000);
        send_request(REQ_SPEED, 16'h8000, 32'd0, 32'd0);
    endtask

    // long random run over several settings, quiet and busy stretches
    task automatic test_random_traffic(int n_items);
        int per_phase;
        int busy;
        per_phase = n_items / 6;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 2)
                write_config('1);
            else if (phase == 4)
                write_config('0);
            else
                write_config(random_config());
            for (int k = 0; k < per_phase; k++)
            begin
                busy = ((k / 64) + phase) % 2;
                tx_gap_pct   = busy ? 30 : 0;
                rx_stall_pct = busy ? 30 : ((phase == 5) ? 20 : 0);
                random_request();
            end
        end
        write_config(random_config());
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        hold_left    = HOLD_OFF_LEN;
        repeat (40)
            random_request();
    endtask

    // sender pauses until every result is back, then carries on
    task automatic test_drain_pause();
        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        repeat (10)
            random_request();
        drain_results();
        repeat (10)
            random_request();
    endtask

    // test sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_step_derivative();
        test_extreme_fields();
        test_deadband_and_band();
        test_limit_lowered();
        test_zero_and_full_limits();
        test_random_traffic(1080);
        test_output_hold_off();
        test_drain_pause();
        drain_results();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
